// File: rtl/cbpm_pkg.sv
// Shared types and codes of the clock buffer pool manager.
package cbpm_pkg;

    localparam int FRAME_W = 6;
    localparam int FILE_W  = 8;
    localparam int PAGE_W  = 24;
    localparam int PIN_W   = 8;

    localparam logic [2:0] CMD_READ     = 3'd0;
    localparam logic [2:0] CMD_ALLOCATE = 3'd1;
    localparam logic [2:0] CMD_UNPIN    = 3'd2;
    localparam logic [2:0] CMD_DISPOSE  = 3'd3;
    localparam logic [2:0] CMD_FLUSH    = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BUSY      = 3'd1;
    localparam logic [2:0] ST_NOTFOUND  = 3'd2;
    localparam logic [2:0] ST_NOTPINNED = 3'd3;
    localparam logic [2:0] ST_PINNED    = 3'd4;

    localparam logic [PIN_W-1:0] PIN_MAX = '1;

    typedef struct packed {
        logic [2:0]        command;
        logic [FILE_W-1:0] file_id;
        logic [PAGE_W-1:0] page_number;
        logic              mark_dirty;
    } t_req;

    typedef struct packed {
        logic [2:0]         status;
        logic [FRAME_W-1:0] frame_index;
        logic               write_back;
        logic [FILE_W-1:0]  victim_file;
        logic [PAGE_W-1:0]  victim_page;
        logic               hit;
        logic               last;
    } t_rsp;

    // One frame table entry; the valid bit lives in flops beside it.
    typedef struct packed {
        logic [FILE_W-1:0] file_id;
        logic [PAGE_W-1:0] page_number;
        logic              referenced;
        logic              dirty;
        logic [PIN_W-1:0]  pins;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LK_RD,
        S_LK_EV,
        S_SW_RD,
        S_SW_EV,
        S_FL_RD,
        S_FL_EV,
        S_FL_DONE
    } t_state;

endpackage

// File: rtl/cbpm_frame_store.sv
// Frame table memory with one read and one write port, plus reset-cleared valid bits.
module cbpm_frame_store
    import cbpm_pkg::*;
#(
    parameter int FRAMES = 16,
    parameter int IW     = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_rd_en,
    input  logic [IW-1:0]  i_rd_addr,
    output t_entry         o_rd_entry,
    output logic           o_rd_valid,
    input  logic           i_wr_en,
    input  logic [IW-1:0]  i_wr_addr,
    input  t_entry         i_wr_entry,
    input  logic           i_wr_valid
);

    t_entry              r_mem [FRAMES];
    logic [FRAMES-1:0]   r_valid;
    t_entry              r_rd_entry;
    logic                r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
        if (i_rd_en) begin
            r_rd_entry <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= i_wr_valid;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_entry = r_rd_entry;
    assign o_rd_valid = r_rd_valid;

endmodule

// File: rtl/clock_buffer_pool_manager.sv
// Top level: frame table sequencer of a clock-replacement buffer pool.
//
//  channel | direction | handshake           | payload
//  request | in        | i_valid / o_stall   | i_req (t_req)
//  result  | out       | o_valid / i_stall   | o_rsp (t_rsp)
//
// Each frame visit is a memory read step, then an evaluate and write-back step.
// Lookup scans frames 0 upward to the first hit; a read miss adds the clock sweep,
// up to 2*FRAMES visits. Flush visits all frames; a pinned one of its file ends it.
// One request at a time; o_stall is high whenever the sequencer is busy.
// Synchronous active-low reset clears valid bits and sets the hand to FRAMES-1.
// A full result register with i_stall high pauses the sequencer before it emits.
module clock_buffer_pool_manager
    import cbpm_pkg::*;
#(
    parameter int FRAMES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = $clog2(2 * FRAMES);
    localparam logic [IW-1:0] LAST_IDX  = IW'(FRAMES - 1);
    localparam logic [CW-1:0] LAST_STEP = CW'(2 * FRAMES - 1);

    t_state          r_state, n_state;
    t_req            r_cmd;
    logic [IW-1:0]   r_idx, n_idx;
    logic [IW-1:0]   r_hand, n_hand;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_ov;
    t_rsp            r_out;

    // memory port
    logic            rd_en;
    logic [IW-1:0]   rd_addr;
    t_entry          rd_entry;
    logic            rd_valid;
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    t_entry          wr_entry;
    logic            wr_valid;

    // emit path
    logic            need_emit;
    logic            emit_fire;
    t_rsp            emit_item;
    logic            emit_ok;
    logic            go;

    logic            accept;
    logic            tag_match;
    logic            file_match;
    logic            sw_take;
    logic [IW-1:0]   hand_inc;

    cbpm_frame_store #(
        .FRAMES (FRAMES),
        .IW     (IW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_entry (rd_entry),
        .o_rd_valid (rd_valid),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_entry (wr_entry),
        .i_wr_valid (wr_valid)
    );

    assign o_stall    = (r_state != S_IDLE);
    assign accept     = i_valid && (r_state == S_IDLE);
    assign emit_ok    = !r_ov || !i_stall;
    assign tag_match  = rd_valid && (rd_entry.file_id == r_cmd.file_id)
                        && (rd_entry.page_number == r_cmd.page_number);
    assign file_match = rd_valid && (rd_entry.file_id == r_cmd.file_id);
    assign sw_take    = !rd_valid || (!rd_entry.referenced && (rd_entry.pins == '0));
    assign hand_inc   = (r_hand == LAST_IDX) ? '0 : r_hand + 1'b1;

    // Does the current evaluate or flush-done step produce a result item?
    always_comb begin
        need_emit = 1'b0;
        case (r_state)
            S_LK_EV: begin
                need_emit = tag_match || (r_idx == LAST_IDX && r_cmd.command != CMD_READ);
            end
            S_SW_EV: begin
                need_emit = sw_take || (r_cnt == LAST_STEP);
            end
            S_FL_EV: begin
                need_emit = file_match && ((rd_entry.pins != '0) || rd_entry.dirty);
            end
            S_FL_DONE: begin
                need_emit = 1'b1;
            end
            default: begin
                need_emit = 1'b0;
            end
        endcase
    end

    assign go        = !need_emit || emit_ok;
    assign emit_fire = need_emit && emit_ok;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req.command == CMD_READ || i_req.command == CMD_UNPIN
                        || i_req.command == CMD_DISPOSE) begin
                        n_state = S_LK_RD;
                    end else if (i_req.command == CMD_ALLOCATE) begin
                        n_state = S_SW_RD;
                    end else if (i_req.command == CMD_FLUSH) begin
                        n_state = S_FL_RD;
                    end
                end
            end
            S_LK_RD: n_state = S_LK_EV;
            S_LK_EV: begin
                if (go) begin
                    if (tag_match) begin
                        n_state = S_IDLE;
                    end else if (r_idx == LAST_IDX) begin
                        n_state = (r_cmd.command == CMD_READ) ? S_SW_RD : S_IDLE;
                    end else begin
                        n_state = S_LK_RD;
                    end
                end
            end
            S_SW_RD: n_state = S_SW_EV;
            S_SW_EV: begin
                if (go) begin
                    n_state = (need_emit) ? S_IDLE : S_SW_RD;
                end
            end
            S_FL_RD: n_state = S_FL_EV;
            S_FL_EV: begin
                if (go) begin
                    if (file_match && rd_entry.pins != '0) begin
                        n_state = S_IDLE;
                    end else if (r_idx == LAST_IDX) begin
                        n_state = S_FL_DONE;
                    end else begin
                        n_state = S_FL_RD;
                    end
                end
            end
            S_FL_DONE: begin
                if (go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_idx     = r_idx;
        n_hand    = r_hand;
        n_cnt     = r_cnt;
        rd_en     = 1'b0;
        rd_addr   = r_idx;
        wr_en     = 1'b0;
        wr_addr   = r_idx;
        wr_entry  = rd_entry;
        wr_valid  = 1'b1;
        emit_item = '0;
        emit_item.last = 1'b1;
        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                n_cnt = '0;
            end
            S_LK_RD, S_FL_RD: begin
                rd_en = 1'b1;
            end
            S_LK_EV: begin
                if (go && !tag_match && r_idx != LAST_IDX) begin
                    n_idx = r_idx + 1'b1;
                end
                emit_item.frame_index = tag_match ? FRAME_W'(r_idx) : '0;
                if (tag_match) begin
                    wr_en = go;
                    case (r_cmd.command)
                        CMD_READ: begin
                            if (rd_entry.pins != PIN_MAX) begin
                                wr_entry.pins = rd_entry.pins + 1'b1;
                            end
                            wr_entry.referenced = 1'b1;
                            emit_item.hit       = 1'b1;
                        end
                        CMD_UNPIN: begin
                            if (rd_entry.pins == '0) begin
                                wr_en            = 1'b0;
                                emit_item.status = ST_NOTPINNED;
                            end else begin
                                wr_entry.pins  = rd_entry.pins - 1'b1;
                                wr_entry.dirty = rd_entry.dirty | r_cmd.mark_dirty;
                            end
                        end
                        default: begin
                            wr_valid = 1'b0;
                        end
                    endcase
                end else if (r_cmd.command == CMD_UNPIN) begin
                    emit_item.status = ST_NOTFOUND;
                end
            end
            S_SW_RD: begin
                n_hand  = hand_inc;
                rd_en   = 1'b1;
                rd_addr = hand_inc;
            end
            S_SW_EV: begin
                wr_addr = r_hand;
                wr_en   = go && (sw_take || rd_entry.referenced);
                n_cnt   = go ? r_cnt + 1'b1 : r_cnt;
                if (sw_take) begin
                    wr_entry.file_id     = r_cmd.file_id;
                    wr_entry.page_number = r_cmd.page_number;
                    wr_entry.referenced  = 1'b1;
                    wr_entry.dirty       = 1'b0;
                    wr_entry.pins        = PIN_W'(1);
                    emit_item.frame_index = FRAME_W'(r_hand);
                    if (rd_valid && rd_entry.dirty) begin
                        emit_item.write_back  = 1'b1;
                        emit_item.victim_file = rd_entry.file_id;
                        emit_item.victim_page = rd_entry.page_number;
                    end
                end else begin
                    wr_entry.referenced = 1'b0;
                    emit_item.status    = ST_BUSY;
                end
            end
            S_FL_EV: begin
                if (go && r_idx != LAST_IDX) begin
                    n_idx = r_idx + 1'b1;
                end
                emit_item.frame_index = FRAME_W'(r_idx);
                if (file_match && rd_entry.pins != '0) begin
                    emit_item.status = ST_PINNED;
                end else begin
                    wr_en                 = go && file_match;
                    wr_valid              = 1'b0;
                    wr_entry.dirty        = 1'b0;
                    emit_item.write_back  = 1'b1;
                    emit_item.victim_file = rd_entry.file_id;
                    emit_item.victim_page = rd_entry.page_number;
                    emit_item.last        = 1'b0;
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hand  <= LAST_IDX;
            r_ov    <= 1'b0;
            r_idx   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_hand  <= n_hand;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            if (emit_fire) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_req;
        end
        if (emit_fire) begin
            r_out <= emit_item;
        end
    end

    assign o_valid = r_ov;
    assign o_rsp   = r_out;

    // sweep never runs past two full passes
    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SW_EV) |-> (r_cnt <= LAST_STEP))
        else $error("sweep step count overrun");

    // a final result item always returns the sequencer to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_fire && emit_item.last) |=> (r_state == S_IDLE))
        else $error("final item without return to idle");

    // memory writes only from evaluate steps
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_LK_EV || r_state == S_SW_EV || r_state == S_FL_EV))
        else $error("frame write outside evaluate step");

    // an unknown command leaves the block idle
    a_unknown_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.command > CMD_FLUSH) |=> (r_state == S_IDLE))
        else $error("unknown command started work");

endmodule
